FILE: hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and fixed widths of the laser path resampler.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int SP_W       = 24;  // spacing, 8 fractional bits
  localparam int DIST_W     = 26;  // carried distance
  localparam int LEN_W      = 25;  // segment length
  localparam int D_W        = 27;  // running emission distance
  localparam int RAD_W      = 50;  // sqrt radicand
  localparam int SQRT_STEPS = 25;
  localparam int MOD_STEPS  = 25;
  localparam int LERP_STEPS = 18;  // product, load, 16 quotient bits
  localparam int QDEPTH     = 2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
    logic               move;
  } item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
    logic               last;
    logic               trunc;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_CHECK, S_LERP, S_EMIT, S_MOD, S_END, S_MOVE
  } bstate_t;

endpackage

FILE: hdl/lpr_if.sv
// ----------------------------------------------------------------------------
// lpr_if
// Request channels of the laser path resampler: points in, points out, config.
// ----------------------------------------------------------------------------
interface lpr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        red;
  logic [15:0]        green;
  logic [15:0]        blue;
  logic               frame_start;
  modport source(output valid, pos_x, pos_y, red, green, blue, frame_start, input ready);
  modport sink(input valid, pos_x, pos_y, red, green, blue, frame_start, output ready);
endinterface

interface lpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [15:0]        out_red;
  logic [15:0]        out_green;
  logic [15:0]        out_blue;
  logic               last;
  logic               truncated;
  modport source(output valid, out_x, out_y, out_red, out_green, out_blue, last, truncated,
                 input ready);
  modport sink(input valid, out_x, out_y, out_red, out_green, out_blue, last, truncated,
               output ready);
endinterface

interface lpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: hdl/lpr_front.sv
// ----------------------------------------------------------------------------
// lpr_front
// Accepts input points and classifies them as move-to or lit segment end.
// ----------------------------------------------------------------------------
module lpr_front (
  lpr_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output lpr_pkg::item_t q_item
);
  import lpr_pkg::*;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_item.x    = in_ch.pos_x;
    q_item.y    = in_ch.pos_y;
    q_item.r    = in_ch.red;
    q_item.g    = in_ch.green;
    q_item.b    = in_ch.blue;
    // blank point or frame start: move-to
    q_item.move = in_ch.frame_start ||
                  (in_ch.red == 16'd0 && in_ch.green == 16'd0 && in_ch.blue == 16'd0);
  end

endmodule

FILE: hdl/lpr_queue.sv
// ----------------------------------------------------------------------------
// lpr_queue
// Short FIFO of classified points between front and back.
// ----------------------------------------------------------------------------
module lpr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpr_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output lpr_pkg::item_t pop_item
);
  import lpr_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         mem_r [QDEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(QDEPTH));
  assign avail    = (cnt_r != '0);
  assign pop_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/lpr_lerp.sv
// ----------------------------------------------------------------------------
// lpr_lerp
// One interpolation lane: a + (b - a) * num / den, rounded, by long division.
// ----------------------------------------------------------------------------
module lpr_lerp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] a_i,
  input  logic signed [16:0] b_i,
  input  logic [24:0]        num_i,
  input  logic [24:0]        den_i,
  output logic               done,
  output logic [15:0]        res
);
  import lpr_pkg::*;

  logic signed [17:0] delta;
  logic               busy_r, done_r, neg_r;
  logic [4:0]         cnt_r;
  logic signed [16:0] a_r;
  logic [15:0]        mag_r, low_r, q_r;
  logic [24:0]        num_r, den_r;
  logic [40:0]        prod_r;
  logic [25:0]        rem_r;
  logic [41:0]        dividend;
  logic [26:0]        trial, divisor;
  logic               ge;
  logic signed [17:0] sum;

  assign delta    = 18'(b_i) - 18'(a_i);
  // numerator 2*mag*num + den over divisor 2*den
  assign dividend = {prod_r, 1'b0} + {17'd0, den_r};
  assign trial    = {rem_r, low_r[15]};
  assign divisor  = {1'b0, den_r, 1'b0};
  assign ge       = (trial >= divisor);
  assign sum      = neg_r ? (18'(a_r) - 18'({2'b0, q_r})) : (18'(a_r) + 18'({2'b0, q_r}));
  assign res      = sum[15:0];
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_i;
      neg_r <= delta[17];
      mag_r <= delta[17] ? 16'(-delta) : delta[15:0];
      num_r <= num_i;
      den_r <= den_i;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        prod_r <= 41'(mag_r) * 41'(num_r);
      end else if (cnt_r == 5'd1) begin
        rem_r <= dividend[41:16];
        low_r <= dividend[15:0];
        q_r   <= '0;
      end else begin
        rem_r <= ge ? 26'(trial - divisor) : trial[25:0];
        low_r <= {low_r[14:0], 1'b0};
        q_r   <= {q_r[14:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'(LERP_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/lpr_back.sv
// ----------------------------------------------------------------------------
// lpr_back
// Segment sequencer: move-to pass-through, length by square root, emissions with
// interpolation, carried distance update, output register.
// ----------------------------------------------------------------------------
module lpr_back #(
  parameter int MAX_EMIT = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [lpr_pkg::SP_W-1:0] spacing,
  input  logic                    q_avail,
  input  lpr_pkg::item_t          q_item,
  output logic                    q_pop,
  output lpr_pkg::result_t        out_data,
  output logic                    out_valid,
  input  logic                    out_ready
);
  import lpr_pkg::*;

  localparam int NW = $clog2(MAX_EMIT + 1);

  bstate_t           state_r, state_nxt;
  item_t             cur_r, cur_nxt, prev_r, prev_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [LEN_W-1:0]  root_r, root_nxt, len_r, len_nxt, mdiv_r, mdiv_nxt;
  logic [26:0]       srem_r, srem_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [D_W-1:0]    d_r, d_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [SP_W-1:0]   mrem_r, mrem_nxt;
  result_t           out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              lane_start;

  logic signed [16:0] dx, dy;
  logic signed [33:0] dx2, dy2;
  logic [33:0]        sq;
  logic [28:0]        s_rem, s_trial;
  logic               s_ge;
  logic [LEN_W-1:0]   s_root;
  logic [SP_W:0]      m_t;
  logic [SP_W-1:0]    m_rem;
  logic [D_W-1:0]     len_ext, nx;
  logic               d_gt, nx_gt, at_max, nx_max, out_free;
  logic [4:0]         lane_done;
  logic [15:0]        lx, ly, lr, lg, lb;
  logic [LEN_W-1:0]   seg_rest;

  assign dx  = 17'(cur_r.x) - 17'(prev_r.x);
  assign dy  = 17'(cur_r.y) - 17'(prev_r.y);
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign sq  = 34'(dx2) + 34'(dy2);

  // one root bit per cycle
  assign s_rem   = {srem_r, rad_r[RAD_W-1 -: 2]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign s_ge    = (s_rem >= s_trial);
  assign s_root  = {root_r[LEN_W-2:0], s_ge};

  // one remainder bit per cycle
  assign m_t   = {mrem_r, mdiv_r[LEN_W-1]};
  assign m_rem = (m_t >= {1'b0, spacing}) ? SP_W'(m_t - {1'b0, spacing}) : m_t[SP_W-1:0];

  assign len_ext  = D_W'(len_r);
  assign nx       = d_r + D_W'(spacing);
  assign d_gt     = (d_r > len_ext);
  assign nx_gt    = (nx > len_ext);
  assign at_max   = (n_r == NW'(MAX_EMIT));
  assign nx_max   = ((n_r + 1'b1) == NW'(MAX_EMIT));
  assign out_free = !out_valid_r || out_ready;
  assign seg_rest = LEN_W'(len_ext - d_r);

  lpr_lerp u_lx (.clk, .rst_n, .start(lane_start), .a_i(17'(prev_r.x)), .b_i(17'(cur_r.x)),
                 .num_i(d_r[LEN_W-1:0]), .den_i(len_r), .done(lane_done[0]), .res(lx));
  lpr_lerp u_ly (.clk, .rst_n, .start(lane_start), .a_i(17'(prev_r.y)), .b_i(17'(cur_r.y)),
                 .num_i(d_r[LEN_W-1:0]), .den_i(len_r), .done(lane_done[1]), .res(ly));
  lpr_lerp u_lr (.clk, .rst_n, .start(lane_start), .a_i({1'b0, prev_r.r}),
                 .b_i({1'b0, cur_r.r}), .num_i(d_r[LEN_W-1:0]), .den_i(len_r),
                 .done(lane_done[2]), .res(lr));
  lpr_lerp u_lg (.clk, .rst_n, .start(lane_start), .a_i({1'b0, prev_r.g}),
                 .b_i({1'b0, cur_r.g}), .num_i(d_r[LEN_W-1:0]), .den_i(len_r),
                 .done(lane_done[3]), .res(lg));
  lpr_lerp u_lb (.clk, .rst_n, .start(lane_start), .a_i({1'b0, prev_r.b}),
                 .b_i({1'b0, cur_r.b}), .num_i(d_r[LEN_W-1:0]), .den_i(len_r),
                 .done(lane_done[4]), .res(lb));

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      dist_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      dist_r      <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    len_r  <= len_nxt;
    cnt_r  <= cnt_nxt;
    d_r    <= d_nxt;
    n_r    <= n_nxt;
    mdiv_r <= mdiv_nxt;
    mrem_r <= mrem_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    dist_nxt      = dist_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    d_nxt         = d_r;
    n_nxt         = n_r;
    mdiv_nxt      = mdiv_r;
    mrem_nxt      = mrem_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    lane_start    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_avail) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = q_item.move ? S_MOVE : S_SQ;
        end
      end
      S_SQ: begin
        rad_nxt   = {sq, 16'd0};
        root_nxt  = '0;
        srem_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        srem_nxt = s_ge ? 27'(s_rem - s_trial) : s_rem[26:0];
        root_nxt = s_root;
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          len_nxt   = s_root;
          d_nxt     = D_W'(dist_r);
          n_nxt     = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (d_gt) begin
          dist_nxt  = DIST_W'(d_r - len_ext);
          state_nxt = S_END;
        end else if (at_max) begin
          if (spacing == '0) begin
            dist_nxt  = '0;
            state_nxt = S_END;
          end else begin
            mrem_nxt  = '0;
            mdiv_nxt  = seg_rest;
            cnt_nxt   = '0;
            state_nxt = S_MOD;
          end
        end else if (len_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          lane_start = 1'b1;
          state_nxt  = S_LERP;
        end
      end
      S_LERP: begin
        if (&lane_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (len_r == '0) begin
            out_nxt.x = cur_r.x;
            out_nxt.y = cur_r.y;
            out_nxt.r = cur_r.r;
            out_nxt.g = cur_r.g;
            out_nxt.b = cur_r.b;
          end else begin
            out_nxt.x = lx;
            out_nxt.y = ly;
            out_nxt.r = lr;
            out_nxt.g = lg;
            out_nxt.b = lb;
          end
          // last and truncation are known from the next emission distance and count
          out_nxt.last  = nx_gt || nx_max;
          out_nxt.trunc = nx_max && !nx_gt;
          out_valid_nxt = 1'b1;
          n_nxt         = n_r + 1'b1;
          d_nxt         = nx;
          state_nxt     = S_CHECK;
        end
      end
      S_MOD: begin
        mrem_nxt = m_rem;
        mdiv_nxt = {mdiv_r[LEN_W-2:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 5'(MOD_STEPS - 1)) begin
          dist_nxt  = DIST_W'(spacing) - DIST_W'(m_rem);
          state_nxt = S_END;
        end
      end
      S_END: begin
        prev_nxt  = cur_r;
        state_nxt = S_IDLE;
      end
      S_MOVE: begin
        if (out_free) begin
          out_nxt.x     = cur_r.x;
          out_nxt.y     = cur_r.y;
          out_nxt.r     = cur_r.r;
          out_nxt.g     = cur_r.g;
          out_nxt.b     = cur_r.b;
          out_nxt.last  = 1'b1;
          out_nxt.trunc = 1'b0;
          out_valid_nxt = 1'b1;
          dist_nxt      = DIST_W'(spacing);
          prev_nxt      = cur_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK || state_r == S_EMIT || state_r == S_LERP) |-> n_r <= NW'(MAX_EMIT))
    else $error("emission count above limit");

  a_move_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && out_free) |=> dist_r == DIST_W'($past(spacing)))
    else $error("move-to did not reload distance");

  a_mod_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> mrem_r < spacing)
    else $error("remainder not below spacing");

  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done != 5'd0) |-> (lane_done == 5'h1f && state_r == S_LERP))
    else $error("interpolation lanes out of step");

endmodule

FILE: hdl/laser_path_resampler.sv
// ----------------------------------------------------------------------------
// laser_path_resampler
// Resamples laser points to equal arc-length spacing along lit segments.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per point (x, y, colour, frame_start).
//   out_ch : resampled points; last marks the final point caused by a request,
//            truncated marks a segment cut at MAX_EMIT points.
//   cfg_ch : spacing write, always ready; write only while the block is idle.
// Sequence:
//   A move-to point goes from the queue through S_MOVE to the output register.
//   A lit segment finds its length by a 25-step square root (S_SQ, S_SQRT);
//   each emitted point then uses five parallel 16-bit long-division lanes (S_LERP);
//   a truncated segment with nonzero spacing adds a 25-step remainder (S_MOD).
//   A segment with no emission returns no output.
//   A two-entry queue behind the input lets the next points wait there.
// Reset: rst_n clears the previous point to black at the origin, the carried
//   distance to zero and spacing to 16384 (64 DAC units).
// Output stall: the result register holds until taken; the sequencer waits.
// ----------------------------------------------------------------------------
module laser_path_resampler #(
  parameter int MAX_EMIT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lpr_in_if.sink    in_ch,
  lpr_out_if.source out_ch,
  lpr_cfg_if.sink   cfg_ch
);
  import lpr_pkg::*;

  logic [SP_W-1:0] spacing_r;
  logic            q_push, q_full, q_pop, q_avail;
  item_t           push_item, pop_item;
  result_t         res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SP_W'(16384);
    end else if (cfg_ch.valid) begin
      spacing_r <= cfg_ch.data;
    end
  end

  lpr_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  lpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_item  (pop_item)
  );

  lpr_back #(.MAX_EMIT(MAX_EMIT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .spacing   (spacing_r),
    .q_avail   (q_avail),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_data  (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.out_x     = res.x;
  assign out_ch.out_y     = res.y;
  assign out_ch.out_red   = res.r;
  assign out_ch.out_green = res.g;
  assign out_ch.out_blue  = res.b;
  assign out_ch.last      = res.last;
  assign out_ch.truncated = res.trunc;

endmodule
